// ===== src/cbfa_pkg.sv =====
// shared types and constants for the contiguous block file allocator
`timescale 1ns / 1ps

package cbfa_pkg;

  // fixed field widths
  localparam int NAME_FIRST_W  = 64;
  localparam int NAME_MIDDLE_W = 64;
  localparam int NAME_LAST_W   = 32;
  localparam int NAME_W        = NAME_FIRST_W + NAME_MIDDLE_W + NAME_LAST_W;
  localparam int LEN_W         = 4;
  localparam int STATUS_W      = 3;
  localparam int START_W       = 7;
  localparam int FILES_W       = 5;

  // request commands
  localparam logic CMD_CREATE = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_CREATED   = 3'd0,
    ST_FULL      = 3'd1,
    ST_NO_RUN    = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_TOO_LARGE = 3'd5
  } status_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_MAP_SCAN,
    OP_MARK,
    OP_APPEND,
    OP_TAB_SCAN,
    OP_FREE,
    OP_SHIFT,
    OP_RESULT
  } dp_op_t;

  // controller to datapath
  typedef struct packed {
    dp_op_t  op;
    status_t res_code;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic is_delete;
    logic full;
    logic too_large;
    logic len_zero;
    logic map_found;
    logic map_done;
    logic left_last;
    logic tab_hit;
    logic hit_len_zero;
    logic tab_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== src/cbfa_req_if.sv =====
// request channel: command, file name and block count
`timescale 1ns / 1ps

interface cbfa_req_if import cbfa_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [NAME_FIRST_W-1:0]  name_bytes_first;
  logic [NAME_MIDDLE_W-1:0] name_bytes_middle;
  logic [NAME_LAST_W-1:0]   name_bytes_last;
  logic [LEN_W-1:0]         request_blocks;

  modport source (
    output valid, command, name_bytes_first, name_bytes_middle, name_bytes_last,
           request_blocks,
    input  ready
  );

  modport sink (
    input  valid, command, name_bytes_first, name_bytes_middle, name_bytes_last,
           request_blocks,
    output ready
  );
endinterface

// ===== src/cbfa_res_if.sv =====
// result channel: status, start block and table fill
`timescale 1ns / 1ps

interface cbfa_res_if import cbfa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [START_W-1:0]  start_block;
  logic [FILES_W-1:0]  files_held;

  modport source (
    output valid, status, start_block, files_held,
    input  ready
  );

  modport sink (
    input  valid, status, start_block, files_held,
    output ready
  );
endinterface

// ===== src/cbfa_ctrl.sv =====
// request sequencer for the allocator
`timescale 1ns / 1ps

module cbfa_ctrl import cbfa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  dp_stat_t stat,
  output logic     in_ready,
  output ctl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_MAP_SCAN,
    S_MARK,
    S_APPEND,
    S_TAB_SCAN,
    S_FREE,
    S_SHIFT,
    S_RESULT
  } state_t;

  state_t  state_r, state_nxt;
  status_t res_code_r, res_code_nxt;

  // next state and result code
  always_comb begin
    state_nxt    = state_r;
    res_code_nxt = res_code_r;
    unique case (state_r)
      S_CLEAR: begin
        if (stat.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        priority if (stat.is_delete) begin
          state_nxt = S_TAB_SCAN;
        end else if (stat.full) begin
          res_code_nxt = ST_FULL;
          state_nxt    = S_RESULT;
        end else if (stat.too_large) begin
          res_code_nxt = ST_TOO_LARGE;
          state_nxt    = S_RESULT;
        end else if (stat.len_zero) begin
          state_nxt = S_APPEND;
        end else begin
          state_nxt = S_MAP_SCAN;
        end
      end
      S_MAP_SCAN: begin
        priority if (stat.map_found) begin
          state_nxt = S_MARK;
        end else if (stat.map_done) begin
          res_code_nxt = ST_NO_RUN;
          state_nxt    = S_RESULT;
        end else begin
          state_nxt = S_MAP_SCAN;
        end
      end
      S_MARK: begin
        if (stat.left_last) state_nxt = S_APPEND;
      end
      S_APPEND: begin
        res_code_nxt = ST_CREATED;
        state_nxt    = S_RESULT;
      end
      S_TAB_SCAN: begin
        priority if (stat.tab_hit) begin
          state_nxt = stat.hit_len_zero ? S_SHIFT : S_FREE;
        end else if (stat.tab_done) begin
          res_code_nxt = ST_NOT_FOUND;
          state_nxt    = S_RESULT;
        end else begin
          state_nxt = S_TAB_SCAN;
        end
      end
      S_FREE: begin
        if (stat.left_last) state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (stat.tab_done) begin
          res_code_nxt = ST_DELETED;
          state_nxt    = S_RESULT;
        end
      end
      S_RESULT: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered result code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      res_code_r <= ST_CREATED;
    end else begin
      state_r    <= state_nxt;
      res_code_r <= res_code_nxt;
    end
  end

  // operation per state
  always_comb begin
    cmd.res_code = res_code_r;
    unique case (state_r)
      S_CLEAR:    cmd.op = OP_CLEAR;
      S_IDLE:     cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_DECIDE:   cmd.op = OP_NONE;
      S_MAP_SCAN: cmd.op = OP_MAP_SCAN;
      S_MARK:     cmd.op = OP_MARK;
      S_APPEND:   cmd.op = OP_APPEND;
      S_TAB_SCAN: cmd.op = OP_TAB_SCAN;
      S_FREE:     cmd.op = OP_FREE;
      S_SHIFT:    cmd.op = OP_SHIFT;
      S_RESULT:   cmd.op = OP_RESULT;
      default:    cmd.op = OP_NONE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// ===== src/cbfa_dpath.sv =====
// block map, file table, scan counters and result register
`timescale 1ns / 1ps

module cbfa_dpath import cbfa_pkg::*; #(
  parameter int BLOCK_COUNT     = 128,
  parameter int FILE_SLOTS      = 16,
  parameter int MAX_FILE_BLOCKS = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctl_cmd_t                 cmd,
  output dp_stat_t                 stat,
  input  logic                     in_command,
  input  logic [NAME_FIRST_W-1:0]  in_name_first,
  input  logic [NAME_MIDDLE_W-1:0] in_name_middle,
  input  logic [NAME_LAST_W-1:0]   in_name_last,
  input  logic [LEN_W-1:0]         in_request_blocks,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [STATUS_W-1:0]      out_status,
  output logic [START_W-1:0]       out_start_block,
  output logic [FILES_W-1:0]       out_files_held
);

  localparam int BW  = $clog2(BLOCK_COUNT);
  localparam int BIW = $clog2(BLOCK_COUNT + 1);
  localparam int SW  = $clog2(FILE_SLOTS);
  localparam int CW  = $clog2(FILE_SLOTS + 1);
  localparam int TW  = NAME_W + BW + LEN_W;

  localparam logic [BIW-1:0]   BLK_END  = BIW'(BLOCK_COUNT);
  localparam logic [BIW-1:0]   BLK_LAST = BIW'(BLOCK_COUNT - 1);
  localparam logic [CW-1:0]    SLOT_END = CW'(FILE_SLOTS);
  localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_FILE_BLOCKS);

  // request and working registers
  logic              cmd_r;
  logic [NAME_W-1:0] name_r;
  logic [LEN_W-1:0]  len_r;
  logic [CW-1:0]     cnt_r;
  logic [BIW-1:0]    blk_idx_r;
  logic [CW-1:0]     slot_idx_r;
  logic [LEN_W-1:0]  run_r;
  logic [LEN_W-1:0]  left_r;
  logic [BW-1:0]     start_r;
  logic [SW-1:0]     wr_slot_r;

  // block map memory and its read stage
  logic              map_mem [BLOCK_COUNT];
  logic              map_q_r;
  logic              map_rd_vld_r;
  logic [BW-1:0]     map_rd_idx_r;

  // file table memory and its read stage
  logic [TW-1:0]     tab_mem [FILE_SLOTS];
  logic [TW-1:0]     tab_q_r;
  logic              tab_rd_vld_r;
  logic [SW-1:0]     tab_rd_idx_r;

  // result register
  logic              out_valid_r;
  status_t           out_status_r;
  logic [START_W-1:0] out_start_r;
  logic [FILES_W-1:0] out_files_r;

  // combinational helpers
  logic              map_issue;
  logic              map_found;
  logic [LEN_W-1:0]  run_inc;
  logic [BIW-1:0]    found_start;
  logic              map_we;
  logic              map_wdata;
  logic              tab_issue;
  logic              tab_hit;
  logic              tab_done;
  logic              tab_we;
  logic [SW-1:0]     tab_waddr;
  logic [TW-1:0]     tab_wdata;
  logic [NAME_W-1:0] q_name;
  logic [BW-1:0]     q_start;
  logic [LEN_W-1:0]  q_len;
  logic              out_free;
  logic              start_shown;
  logic [BW+START_W-1:0] start_ext;
  logic [CW+FILES_W-1:0] files_ext;

  // first-fit run search on the registered map read
  assign map_issue   = (cmd.op == OP_MAP_SCAN) && (blk_idx_r < BLK_END);
  assign run_inc     = run_r + LEN_W'(1);
  assign map_found   = (cmd.op == OP_MAP_SCAN) && map_rd_vld_r && !map_q_r &&
                       (run_inc == len_r);
  assign found_start = BIW'(map_rd_idx_r) + BIW'(1) - BIW'(len_r);

  // map write: clear pass, mark on create, free on delete
  assign map_we    = (cmd.op == OP_CLEAR) || (cmd.op == OP_MARK) || (cmd.op == OP_FREE);
  assign map_wdata = (cmd.op == OP_MARK);

  // table scan by name and compaction after a delete
  assign q_name    = tab_q_r[TW-1 -: NAME_W];
  assign q_start   = tab_q_r[LEN_W +: BW];
  assign q_len     = tab_q_r[LEN_W-1:0];
  assign tab_issue = ((cmd.op == OP_TAB_SCAN) || (cmd.op == OP_SHIFT)) &&
                     (slot_idx_r < cnt_r);
  assign tab_hit   = (cmd.op == OP_TAB_SCAN) && tab_rd_vld_r && (q_name == name_r);
  assign tab_done  = !tab_rd_vld_r && (slot_idx_r == cnt_r);

  // table write: append on create, move down on delete
  always_comb begin
    tab_we    = 1'b0;
    tab_waddr = wr_slot_r;
    tab_wdata = tab_q_r;
    if (cmd.op == OP_APPEND) begin
      tab_we    = 1'b1;
      tab_waddr = cnt_r[SW-1:0];
      tab_wdata = {name_r, start_r, len_r};
    end else if ((cmd.op == OP_SHIFT) && tab_rd_vld_r) begin
      tab_we = 1'b1;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  // status to the controller
  assign stat.clear_last   = (blk_idx_r == BLK_LAST);
  assign stat.is_delete    = (cmd_r == CMD_DELETE);
  assign stat.full         = (cnt_r >= SLOT_END);
  assign stat.too_large    = (len_r > MAX_LEN);
  assign stat.len_zero     = (len_r == '0);
  assign stat.map_found    = map_found;
  assign stat.map_done     = !map_rd_vld_r && (blk_idx_r == BLK_END);
  assign stat.left_last    = (left_r == LEN_W'(1));
  assign stat.tab_hit      = tab_hit;
  assign stat.hit_len_zero = (q_len == '0);
  assign stat.tab_done     = tab_done;
  assign stat.out_free     = out_free;

  // block map memory
  always_ff @(posedge clk) begin
    if (map_we) map_mem[blk_idx_r[BW-1:0]] <= map_wdata;
    if (map_issue) map_q_r <= map_mem[blk_idx_r[BW-1:0]];
  end

  // file table memory
  always_ff @(posedge clk) begin
    if (tab_we) tab_mem[tab_waddr] <= tab_wdata;
    if (tab_issue) tab_q_r <= tab_mem[slot_idx_r[SW-1:0]];
  end

  // control counters and valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_idx_r    <= '0;
      slot_idx_r   <= '0;
      cnt_r        <= '0;
      map_rd_vld_r <= 1'b0;
      tab_rd_vld_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      map_rd_vld_r <= map_issue && !map_found;
      tab_rd_vld_r <= tab_issue && !tab_hit;

      unique case (cmd.op)
        OP_CLEAR, OP_MARK, OP_FREE: blk_idx_r <= blk_idx_r + BIW'(1);
        OP_LOAD: begin
          blk_idx_r  <= '0;
          slot_idx_r <= '0;
        end
        OP_MAP_SCAN: begin
          if (map_found) blk_idx_r <= found_start;
          else if (map_issue) blk_idx_r <= blk_idx_r + BIW'(1);
        end
        OP_TAB_SCAN: begin
          if (tab_hit) begin
            blk_idx_r  <= BIW'(q_start);
            slot_idx_r <= CW'(tab_rd_idx_r) + CW'(1);
          end else if (tab_issue) begin
            slot_idx_r <= slot_idx_r + CW'(1);
          end
        end
        OP_SHIFT: begin
          if (tab_issue) slot_idx_r <= slot_idx_r + CW'(1);
          if (tab_done) cnt_r <= cnt_r - CW'(1);
        end
        OP_APPEND: cnt_r <= cnt_r + CW'(1);
        OP_NONE, OP_RESULT: ;
        default: ;
      endcase

      if ((cmd.op == OP_RESULT) && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // request payload and scan bookkeeping
  always_ff @(posedge clk) begin
    map_rd_idx_r <= blk_idx_r[BW-1:0];
    tab_rd_idx_r <= slot_idx_r[SW-1:0];
    unique case (cmd.op)
      OP_LOAD: begin
        cmd_r   <= in_command;
        name_r  <= {in_name_first, in_name_middle, in_name_last};
        len_r   <= in_request_blocks;
        start_r <= '0;
        run_r   <= '0;
      end
      OP_MAP_SCAN: begin
        if (map_rd_vld_r) run_r <= map_q_r ? '0 : run_inc;
        if (map_found) begin
          start_r <= found_start[BW-1:0];
          left_r  <= len_r;
        end
      end
      OP_MARK, OP_FREE: left_r <= left_r - LEN_W'(1);
      OP_TAB_SCAN: begin
        if (tab_hit) begin
          start_r   <= q_start;
          left_r    <= q_len;
          wr_slot_r <= tab_rd_idx_r;
        end
      end
      OP_SHIFT: begin
        if (tab_rd_vld_r) wr_slot_r <= wr_slot_r + SW'(1);
      end
      OP_NONE, OP_CLEAR, OP_APPEND, OP_RESULT: ;
      default: ;
    endcase
  end

  // result register load
  assign start_shown = (cmd.res_code == ST_CREATED) || (cmd.res_code == ST_DELETED);
  assign start_ext   = {{START_W{1'b0}}, start_r};
  assign files_ext   = {{FILES_W{1'b0}}, cnt_r};

  always_ff @(posedge clk) begin
    if ((cmd.op == OP_RESULT) && out_free) begin
      out_status_r <= cmd.res_code;
      out_start_r  <= start_shown ? start_ext[START_W-1:0] : '0;
      out_files_r  <= files_ext[FILES_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_start_block = out_start_r;
  assign out_files_held  = out_files_r;

  // table fill never passes the slot count
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SLOT_END)
    else $error("file count above slot count");

  // an append only happens with a free slot
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_APPEND) |-> (cnt_r < SLOT_END))
    else $error("append into a full table");

  // a new result only comes from a result load
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.op == OP_RESULT))
    else $error("result valid without a load");

  // start block only shown for created or deleted files
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_CREATED) && (out_status_r != ST_DELETED))
      |-> (out_start_r == '0))
    else $error("start block set on a failed request");

endmodule

// ===== src/contiguous_block_file_allocator_core.sv =====
// top level of the first-fit contiguous block file allocator
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    command, 160-bit name, request_blocks
//   out_ch   out  valid/ready    status, start_block, files_held
//
// a create reads the block map one flag a cycle; a delete searches the table
// and compacts it in one walk. after reset a clearing pass frees every block
// before the first item; a stalled result holds one item while the next is worked on.
`timescale 1ns / 1ps

module contiguous_block_file_allocator_core import cbfa_pkg::*; #(
  parameter int BLOCK_COUNT     = 128,
  parameter int FILE_SLOTS      = 16,
  parameter int MAX_FILE_BLOCKS = 10
) (
  input logic        clk,
  input logic        rst_n,
  cbfa_req_if.sink   in_ch,
  cbfa_res_if.source out_ch
);

  ctl_cmd_t cmd;
  dp_stat_t stat;
  logic     in_ready;

  // request sequencer
  cbfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // storage, counters and result register
  cbfa_dpath #(
    .BLOCK_COUNT     (BLOCK_COUNT),
    .FILE_SLOTS      (FILE_SLOTS),
    .MAX_FILE_BLOCKS (MAX_FILE_BLOCKS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_command        (in_ch.command),
    .in_name_first     (in_ch.name_bytes_first),
    .in_name_middle    (in_ch.name_bytes_middle),
    .in_name_last      (in_ch.name_bytes_last),
    .in_request_blocks (in_ch.request_blocks),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_status        (out_ch.status),
    .out_start_block   (out_ch.start_block),
    .out_files_held    (out_ch.files_held)
  );

  assign in_ch.ready = in_ready;

endmodule
